@@ rtl/bfhp_pkg.sv @@
// Shared types, codes and the magic table of the bit file header parser.
package bfhp_pkg;

  localparam int unsigned MagicLen  = 13;
  localparam logic [7:0]  EndLetter = 8'h65;

  // Status codes carried on the result channel
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [1:0] ST_PAST  = 2'd3;

  typedef enum logic [3:0] {
    PH_MAGIC  = 4'd0,
    PH_LETTER = 4'd1,
    PH_LEN_HI = 4'd2,
    PH_LEN_LO = 4'd3,
    PH_TEXT   = 4'd4,
    PH_E      = 4'd5,
    PH_BLEN   = 4'd6,
    PH_DONE   = 4'd7,
    PH_ERROR  = 4'd8
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        text_valid;
    logic [1:0]  text_section;
    logic [7:0]  text_byte;
    logic [31:0] bitstream_length;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h00;
      4'd1:    val = 8'h09;
      4'd2:    val = 8'h0f;
      4'd3:    val = 8'hf0;
      4'd4:    val = 8'h0f;
      4'd5:    val = 8'hf0;
      4'd6:    val = 8'h0f;
      4'd7:    val = 8'hf0;
      4'd8:    val = 8'h0f;
      4'd9:    val = 8'hf0;
      4'd10:   val = 8'h00;
      4'd11:   val = 8'h00;
      4'd12:   val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/bfhp_parser.sv @@
// Header parsing state machine: one byte per step, result formed combinationally.
module bfhp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output bfhp_pkg::result_t res
);
  import bfhp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [1:0]  sect_r, sect_nxt;
  logic [31:0] acc_r, acc_nxt;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sect_nxt  = sect_r;
    acc_nxt   = acc_r;
    if (phase_r == PH_DONE || phase_r == PH_ERROR) begin
      phase_nxt = phase_r;
    end else if (stream_end) begin
      phase_nxt = PH_ERROR;
    end else begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (count_r >= 16'(MagicLen) || data_byte != magic_byte(count_r[3:0])) begin
            phase_nxt = PH_ERROR;
          end else if (count_r == 16'(MagicLen - 1)) begin
            count_nxt = '0;
            phase_nxt = PH_LETTER;
          end else begin
            count_nxt = count_r + 16'd1;
          end
        end
        PH_LETTER: phase_nxt = PH_LEN_HI;
        PH_LEN_HI: begin
          count_nxt = {data_byte, 8'h00};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          count_nxt = {count_r[15:8], data_byte};
          phase_nxt = ({count_r[15:8], data_byte} == 16'd0) ? PH_ERROR : PH_TEXT;
        end
        PH_TEXT: begin
          if (count_r <= 16'd1) begin
            count_nxt = '0;
            if (data_byte != 8'h00) begin
              phase_nxt = PH_ERROR;
            end else if (sect_r == 2'd3) begin
              phase_nxt = PH_E;
            end else begin
              sect_nxt  = sect_r + 2'd1;
              phase_nxt = PH_LETTER;
            end
          end else begin
            count_nxt = count_r - 16'd1;
          end
        end
        PH_E: begin
          if (data_byte != EndLetter) begin
            phase_nxt = PH_ERROR;
          end else begin
            count_nxt = '0;
            acc_nxt   = '0;
            phase_nxt = PH_BLEN;
          end
        end
        PH_BLEN: begin
          acc_nxt = {acc_r[23:0], data_byte};
          if (count_r >= 16'd3) begin
            count_nxt = '0;
            phase_nxt = PH_DONE;
          end else begin
            count_nxt = count_r + 16'd1;
          end
        end
        default: phase_nxt = PH_ERROR;
      endcase
    end
  end

  // Result fields
  always_comb begin
    res = '0;
    if (phase_r == PH_DONE) begin
      res.status           = ST_PAST;
      res.bitstream_length = acc_r;
    end else if (phase_r == PH_ERROR) begin
      res.status = ST_ERROR;
    end else begin
      if (phase_r == PH_TEXT && !stream_end) begin
        res.text_valid   = 1'b1;
        res.text_section = sect_r;
        res.text_byte    = data_byte;
      end
      if (phase_nxt == PH_ERROR) begin
        res.status = ST_ERROR;
      end else if (phase_r == PH_BLEN && phase_nxt == PH_DONE) begin
        res.status           = ST_DONE;
        res.bitstream_length = acc_nxt;
      end else begin
        res.status = ST_BUSY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      count_r <= '0;
      sect_r  <= '0;
      acc_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sect_r  <= sect_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

@@ rtl/bfhp_out_stage.sv @@
// Result register with valid/stall handshake towards the consumer.
module bfhp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bfhp_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output bfhp_pkg::result_t out_res
);
  import bfhp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/bit_file_header_parser.sv @@
// Top level of the bit file header parser: input register, parser and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in_     | request   | in_valid / in_stall | in_data_byte, in_stream_end
//  out_    | result    | out_valid/out_stall | out_status, out_text_valid,
//          |           |                     | out_text_section, out_text_byte,
//          |           |                     | out_bitstream_length
//
// One result per request. A request is taken into the input register, parsed
// there and its result lands in the result register; one request per cycle is
// sustained while the result side does not stall, set by the single parser step.
// rst_n is synchronous and active low; it returns the parser to the magic check.
// A stall on the result side holds the result register and then the input
// register; in_stall rises only when both are full.
module bit_file_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_text_valid,
  output logic [1:0]  out_text_section,
  output logic [7:0]  out_text_byte,
  output logic [31:0] out_bitstream_length
);
  import bfhp_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       free;
  logic       advance;
  result_t    res;
  result_t    out_res;

  // Advance the parser whenever a request sits in the input register and the
  // result register can take its result.
  assign advance  = s1_valid_r && free;
  assign in_stall = s1_valid_r && !free;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture payload only on a taken request; hold it otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_stream_end;
    end
  end

  bfhp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .data_byte  (s1_byte_r),
    .stream_end (s1_end_r),
    .res        (res)
  );

  bfhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_valid_r),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status           = out_res.status;
  assign out_text_valid       = out_res.text_valid;
  assign out_text_section     = out_res.text_section;
  assign out_text_byte        = out_res.text_byte;
  assign out_bitstream_length = out_res.bitstream_length;

endmodule

@@ bench/bit_file_header_parser_test.sv @@
// Self-checking bench for the bit file header parser: one random file per run, scoreboard checked.
module bit_file_header_parser_test;
  import bfhp_pkg::*;

  class header_scoreboard;
    logic [7:0]  magic_seq [0:12] = '{8'h00, 8'h09, 8'h0f, 8'hf0, 8'h0f, 8'hf0, 8'h0f,
                                      8'hf0, 8'h0f, 8'hf0, 8'h00, 8'h00, 8'h01};
    phase_t      phase      = PH_MAGIC;
    logic [15:0] remaining  = '0;
    logic [1:0]  section    = '0;
    logic [31:0] bit_length = '0;
    result_t     expected_results [$];
    int unsigned mismatches = 0;

    function automatic result_t parse_byte(logic [7:0] data, logic last);
      result_t r;
      r = '0;
      if (phase == PH_DONE) begin
        r.status           = ST_PAST;
        r.bitstream_length = bit_length;
      end else if (phase == PH_ERROR) begin
        r.status = ST_ERROR;
      end else if (last) begin
        phase    = PH_ERROR;
        r.status = ST_ERROR;
      end else begin
        case (phase)
          PH_MAGIC: begin
            if (remaining >= MagicLen || data != magic_seq[remaining[3:0]]) begin
              phase = PH_ERROR;
            end else if (remaining == MagicLen - 1) begin
              remaining = '0;
              phase     = PH_LETTER;
            end else begin
              remaining = remaining + 16'd1;
            end
          end
          PH_LETTER: phase = PH_LEN_HI;
          PH_LEN_HI: begin
            remaining = {data, 8'h00};
            phase     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            remaining = remaining | {8'h00, data};
            phase     = (remaining == 16'd0) ? PH_ERROR : PH_TEXT;
          end
          PH_TEXT: begin
            r.text_valid   = 1'b1;
            r.text_section = section;
            r.text_byte    = data;
            if (remaining <= 16'd1) begin
              remaining = '0;
              if (data != 8'h00) begin
                phase = PH_ERROR;
              end else if (section == 2'd3) begin
                phase = PH_E;
              end else begin
                section = section + 2'd1;
                phase   = PH_LETTER;
              end
            end else begin
              remaining = remaining - 16'd1;
            end
          end
          PH_E: begin
            if (data != EndLetter) begin
              phase = PH_ERROR;
            end else begin
              remaining  = '0;
              bit_length = '0;
              phase      = PH_BLEN;
            end
          end
          PH_BLEN: begin
            bit_length = {bit_length[23:0], data};
            if (remaining >= 16'd3) begin
              remaining          = '0;
              phase              = PH_DONE;
              r.status           = ST_DONE;
              r.bitstream_length = bit_length;
            end else begin
              remaining = remaining + 16'd1;
            end
          end
          default: phase = PH_ERROR;
        endcase
        if (phase == PH_ERROR) begin
          r.status           = ST_ERROR;
          r.bitstream_length = '0;
        end
      end
      return r;
    endfunction

    function void note_request(logic [7:0] data, logic last);
      expected_results.push_back(parse_byte(data, last));
    endfunction

    function void check_result(logic [1:0] status, logic text_valid, logic [1:0] text_section,
                               logic [7:0] text_byte, logic [31:0] bitstream_length);
      result_t e;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        mismatches++;
      end
      if (text_valid !== e.text_valid) begin
        $error("text_valid: expected %0d, got %0d", e.text_valid, text_valid);
        mismatches++;
      end
      if (text_section !== e.text_section) begin
        $error("text_section: expected %0d, got %0d", e.text_section, text_section);
        mismatches++;
      end
      if (text_byte !== e.text_byte) begin
        $error("text_byte: expected %0h, got %0h", e.text_byte, text_byte);
        mismatches++;
      end
      if (bitstream_length !== e.bitstream_length) begin
        $error("bitstream_length: expected %0h, got %0h", e.bitstream_length,
               bitstream_length);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  localparam int FileItems  = 1350;
  localparam int QuietItems = 150;      // no idling on either side for the last requests
  localparam int DrainCycles = 8;       // margin for stray results to show
  localparam int CycleLimit  = 400000;

  // How the file is spoilt, if at all; the parser is sticky, so one fate per run
  typedef enum int {
    FATE_CLEAN, FATE_BAD_MAGIC, FATE_ZERO_LEN, FATE_BAD_TERM, FATE_BAD_END_LETTER, FATE_EARLY_END
  } fate_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_text_valid;
  logic [1:0]  out_text_section;
  logic [7:0]  out_text_byte;
  logic [31:0] out_bitstream_length;

  header_scoreboard board;
  request_t         file_q [$];
  bit               quiet_tail = 1'b0;
  int               cycle_count = 0;

  bit_file_header_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_stream_end        (in_stream_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_text_valid       (out_text_valid),
    .out_text_section     (out_text_section),
    .out_text_byte        (out_text_byte),
    .out_bitstream_length (out_bitstream_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one byte of the file to the request queue
  task automatic push_byte(logic [7:0] data);
    file_q.push_back('{data: data, last: 1'b0});
  endtask

  // Build the whole byte stream of this run: a well-formed header, then
  // perhaps one fault, then trailing noise that the sticky parser must ride out.
  task automatic build_file();
    logic [15:0] lens [4];
    logic [31:0] blen;
    logic [7:0]  v;
    int          len_lo_at [4];
    int          term_at [4];
    int          e_at;
    int          long_sec;
    int          s;
    int          k;
    int          pos;
    int          fill_to;
    int          pick;
    fate_t       fate;

    long_sec = $urandom_range(0, 3);
    for (k = 0; k < 13; k++) push_byte(board.magic_seq[k]);

    for (s = 0; s < 4; s++) begin
      // letter byte is discarded: hit both extremes, random otherwise
      if (s == 0) push_byte(8'h00);
      else if (s == 3) push_byte(8'hff);
      else push_byte(8'($urandom_range(0, 255)));
      // one section long enough to need the high length byte; some hold just the terminator
      if (s == long_sec) lens[s] = 16'($urandom_range(256, 320));
      else if ($urandom_range(0, 3) == 0) lens[s] = 16'd1;
      else lens[s] = 16'($urandom_range(2, 150));
      push_byte(lens[s][15:8]);
      len_lo_at[s] = file_q.size();
      push_byte(lens[s][7:0]);
      for (k = 0; k < int'(lens[s]) - 1; k++) begin
        // embedded zeros are plain content, only the last byte terminates
        v = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        push_byte(v);
      end
      term_at[s] = file_q.size();
      push_byte(8'h00);
    end

    e_at = file_q.size();
    push_byte(EndLetter);
    blen = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : 32'($urandom);
    for (k = 3; k >= 0; k--) push_byte(blen[k*8 +: 8]);

    // Most runs parse the header cleanly; the rest take one fault
    pick = $urandom_range(0, 12);
    fate = (pick < 8) ? FATE_CLEAN : fate_t'(pick - 7);
    s    = $urandom_range(0, 3);
    case (fate)
      FATE_BAD_MAGIC: begin
        pos = $urandom_range(0, 12);
        file_q[pos].data = file_q[pos].data ^ (8'h01 << $urandom_range(0, 7));
      end
      FATE_ZERO_LEN: begin
        pos = len_lo_at[s];
        file_q[pos - 1].data = 8'h00;
        file_q[pos].data     = 8'h00;
      end
      FATE_BAD_TERM: begin
        pos = term_at[s];
        file_q[pos].data = 8'($urandom_range(1, 255));
      end
      FATE_BAD_END_LETTER: begin
        pos = e_at;
        file_q[pos].data = EndLetter ^ 8'($urandom_range(1, 255));
      end
      FATE_EARLY_END: begin
        pos = $urandom_range(0, file_q.size() - 1);
        file_q[pos].last = 1'b1;
      end
      default: pos = file_q.size() - 1;
    endcase
    // drop whatever followed the fault
    while (file_q.size() > pos + 1) void'(file_q.pop_back());

    // Trailing bytes, with the odd end-of-stream marker mixed in
    fill_to = (pos + 101 > FileItems) ? pos + 101 : FileItems;
    while (file_q.size() < fill_to) begin
      file_q.push_back('{data: 8'($urandom_range(0, 255)),
                         last: ($urandom_range(0, 15) == 0)});
    end
  endtask

  // Feed the file one request at a time, with idle bursts that vary in
  // density every 64 requests; hold each request until it is taken.
  task automatic send_file();
    int i;
    int idle_rate;
    idle_rate = 0;
    for (i = 0; i < file_q.size(); i++) begin
      if (i % 64 == 0) idle_rate = $urandom_range(0, 2);
      quiet_tail = (i >= int'(file_q.size()) - QuietItems);
      if (!quiet_tail && idle_rate != 0 &&
          $urandom_range(0, (idle_rate == 1) ? 7 : 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= file_q[i].data;
      in_stream_end <= file_q[i].last;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.note_request(file_q[i].data, file_q[i].last);
    end
    in_valid <= 1'b0;
  endtask

  // Result side: stall in bursts of random length, none in the quiet tail
  initial begin
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet_tail && $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Sample the result channel on the edge that takes the result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_status, out_text_valid, out_text_section,
                         out_text_byte, out_bitstream_length);
    end
  end

  // Watchdog: a hung handshake ends the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'h00;
    in_stream_end <= 1'b0;
    board = new();
    build_file();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_file();
    // drain: wait for every outstanding result, then allow stray ones to show
    while (board.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
